### hw/rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// Timing wheel scheduler package
// Shared widths, codes and the control word between sequencer and store.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

	localparam int DATA_W      = 32;
	localparam int HID_W       = 8;
	localparam int STATUS_W    = 2;
	localparam int SLOTS_DEF   = 10;
	localparam int ENTRIES_DEF = 8;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [DATA_W-1:0] GRAN_RESET = 32'd1000000;

	localparam logic MODE_INSTALL = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	localparam logic KIND_INSTALL = 1'b0;
	localparam logic KIND_EXPIRE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SPAN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	localparam logic REG_GRAN = 1'b0;

	typedef struct packed {
		logic fill_rd;
		logic fill_wr;
		logic fill_clr;
		logic ent_rd;
		logic ent_wr;
	} store_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/tws_if.sv
// ----------------------------------------------------------------------------
// Timing wheel scheduler channels
// Request channel into the block and report channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface tws_cmd_if import tws_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [DATA_W-1:0] deadline;
	logic [HID_W-1:0]  handler_id;

	modport source (output valid, mode, deadline, handler_id, input ready);
	modport sink (input valid, mode, deadline, handler_id, output ready);
endinterface

interface tws_rpt_if import tws_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [STATUS_W-1:0] status;
	logic [HID_W-1:0]    fired_handler;
	logic [DATA_W-1:0]   fired_deadline;
	logic                last;

	modport source (output valid, kind, status, fired_handler, fired_deadline, last,
		input ready);
	modport sink (input valid, kind, status, fired_handler, fired_deadline, last,
		output ready);
endinterface

`default_nettype wire

### hw/rtl/tws_div.sv
// ----------------------------------------------------------------------------
// Timing wheel divider
// Restoring divider, one quotient bit per cycle over the full data width.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_div import tws_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DATA_W-1:0] dividend,
	input  wire logic [DATA_W-1:0] divisor,
	output logic                   done,
	output logic [DATA_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              neg;

	assign shifted = {rem_q, acc_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign neg     = diff[DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= neg ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
			acc_q <= {acc_q[DATA_W-2:0], ~neg};
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

`default_nettype wire

### hw/rtl/tws_store.sv
// ----------------------------------------------------------------------------
// Timing wheel store
// Per-slot fill counts with valid bits, and the timer entry memory.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_store import tws_pkg::*; #(
	parameter int SLOTS            = SLOTS_DEF,
	parameter int ENTRIES_PER_SLOT = ENTRIES_DEF,
	localparam int SLOT_W = $clog2(SLOTS),
	localparam int IDX_W  = (ENTRIES_PER_SLOT > 1) ? $clog2(ENTRIES_PER_SLOT) : 1,
	localparam int FILL_W = $clog2(ENTRIES_PER_SLOT + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire store_cmd_t        cmd,
	input  wire logic [SLOT_W-1:0] slot,
	input  wire logic [IDX_W-1:0]  idx,
	input  wire logic [FILL_W-1:0] fill_wdata,
	input  wire logic [HID_W-1:0]  hid_wdata,
	input  wire logic [DATA_W-1:0] dl_wdata,
	output logic [FILL_W-1:0]      fill,
	output logic [HID_W-1:0]       hid,
	output logic [DATA_W-1:0]      dl
);

	localparam int DEPTH  = SLOTS * ENTRIES_PER_SLOT;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [FILL_W-1:0]        fill_mem [SLOTS];
	logic [HID_W+DATA_W-1:0]  ent_mem [DEPTH];
	logic [SLOTS-1:0]         vld_q;
	logic                     vld_rd_q;
	logic [FILL_W-1:0]        fill_rd_q;
	logic [HID_W+DATA_W-1:0]  ent_rd_q;
	logic [ADDR_W-1:0]        ent_addr;

	assign ent_addr = ADDR_W'(slot) * ADDR_W'(ENTRIES_PER_SLOT) + ADDR_W'(idx);

	// A slot whose valid bit is clear holds no timers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (cmd.fill_wr) begin
				vld_q[slot] <= 1'b1;
			end else if (cmd.fill_clr) begin
				vld_q[slot] <= 1'b0;
			end
			if (cmd.fill_rd) begin
				vld_rd_q <= vld_q[slot];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_wr) begin
			fill_mem[slot] <= fill_wdata;
		end
		if (cmd.fill_rd) begin
			fill_rd_q <= fill_mem[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ent_wr) begin
			ent_mem[ent_addr] <= {hid_wdata, dl_wdata};
		end
		if (cmd.ent_rd) begin
			ent_rd_q <= ent_mem[ent_addr];
		end
	end

	assign fill = vld_rd_q ? fill_rd_q : '0;
	assign hid  = ent_rd_q[HID_W+DATA_W-1:DATA_W];
	assign dl   = ent_rd_q[DATA_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/timing_wheel_scheduler_top.sv
// ----------------------------------------------------------------------------
// Timing wheel scheduler top level
// Single-level hashed timing wheel with install and tick requests.
// ----------------------------------------------------------------------------
// The block takes one request at a time. An install runs the deadline through
// a restoring divider, one quotient bit per cycle. Its status report is loaded
// in S_IRESP, after S_DIV and S_FCHK or, beyond the wheel span, after S_DIV
// alone, and the next request can be taken in the cycle after. A tick reads
// the slot fill, then reports each expired timer in turn, paced by the entry
// memory read port and the report register. Every slot starts empty right
// after reset; there is no clearing pass.
`default_nettype none

module timing_wheel_scheduler_top import tws_pkg::*; #(
	parameter int SLOTS            = SLOTS_DEF,
	parameter int ENTRIES_PER_SLOT = ENTRIES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tws_cmd_if.sink                cmd,
	tws_rpt_if.source              rpt,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int IDX_W  = (ENTRIES_PER_SLOT > 1) ? $clog2(ENTRIES_PER_SLOT) : 1;
	localparam int FILL_W = $clog2(ENTRIES_PER_SLOT + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DIV   = 6'b000010,
		S_FCHK  = 6'b000100,
		S_IRESP = 6'b001000,
		S_TFILL = 6'b010000,
		S_TOUT  = 6'b100000
	} state_t;

	state_t              state_q;
	logic [DATA_W-1:0]   gran_q;
	logic [SLOT_W-1:0]   cur_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [DATA_W-1:0]   dl_q;
	logic [HID_W-1:0]    hid_q;
	logic [STATUS_W-1:0] status_q;
	logic [FILL_W-1:0]   n_q;
	logic [FILL_W-1:0]   idx_q;

	logic                rpt_valid_q;
	logic                rpt_kind_q;
	logic [STATUS_W-1:0] rpt_status_q;
	logic [HID_W-1:0]    rpt_hid_q;
	logic [DATA_W-1:0]   rpt_dl_q;
	logic                rpt_last_q;

	logic                cfg_wr;
	logic                cmd_acc;
	logic                div_start;
	logic                div_done;
	logic [DATA_W-1:0]   div_quo;
	logic                q_over;
	logic [SLOT_W:0]     slot_sum;
	logic [SLOT_W-1:0]   slot_nx;
	logic [SLOT_W-1:0]   cur_nx;
	logic                out_free;
	logic                tout_last;
	logic                rpt_load_inst;
	logic                rpt_load_exp;
	store_cmd_t          st_cmd;
	logic [SLOT_W-1:0]   st_slot;
	logic [IDX_W-1:0]    st_idx;
	logic [FILL_W-1:0]   st_fill;
	logic [HID_W-1:0]    st_hid;
	logic [DATA_W-1:0]   st_dl;
	logic                fill_full;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_GRAN);
	assign prdata = (paddr[2] == REG_GRAN) ? gran_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gran_q <= GRAN_RESET;
		end else if (cfg_wr) begin
			gran_q <= pwdata;
		end
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign div_start = cmd_acc && (cmd.mode == MODE_INSTALL);

	// A zero granularity yields an all-ones quotient and is refused as beyond span.
	tws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cmd.deadline),
		.divisor  (gran_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign q_over   = (div_quo >= DATA_W'(SLOTS));
	assign slot_sum = {1'b0, cur_q} + {1'b0, div_quo[SLOT_W-1:0]};
	assign slot_nx  = (slot_sum >= (SLOT_W+1)'(SLOTS)) ?
		SLOT_W'(slot_sum - (SLOT_W+1)'(SLOTS)) : slot_sum[SLOT_W-1:0];
	assign cur_nx   = (cur_q == SLOT_W'(SLOTS - 1)) ? '0 : cur_q + 1'b1;

	assign out_free  = !rpt_valid_q || rpt.ready;
	assign tout_last = (idx_q + 1'b1 == n_q);
	assign fill_full = (st_fill >= FILL_W'(ENTRIES_PER_SLOT));

	always_comb begin
		st_cmd        = '0;
		st_slot       = cur_q;
		st_idx        = '0;
		rpt_load_inst = 1'b0;
		rpt_load_exp  = 1'b0;
		case (state_q)
			S_IDLE: begin
				st_cmd.fill_rd = cmd_acc && (cmd.mode == MODE_TICK);
			end
			S_DIV: begin
				st_slot        = slot_nx;
				st_cmd.fill_rd = div_done && !q_over;
			end
			S_FCHK: begin
				st_slot        = slot_q;
				st_idx         = IDX_W'(st_fill);
				st_cmd.fill_wr = !fill_full;
				st_cmd.ent_wr  = !fill_full;
			end
			S_IRESP: begin
				rpt_load_inst = out_free;
			end
			S_TFILL: begin
				st_cmd.ent_rd = (st_fill != '0);
			end
			S_TOUT: begin
				rpt_load_exp    = out_free;
				st_idx          = IDX_W'(idx_q + 1'b1);
				st_cmd.ent_rd   = out_free && !tout_last;
				st_cmd.fill_clr = out_free && tout_last;
			end
			default: begin
				st_cmd = '0;
			end
		endcase
	end

	tws_store #(
		.SLOTS            (SLOTS),
		.ENTRIES_PER_SLOT (ENTRIES_PER_SLOT)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (st_cmd),
		.slot       (st_slot),
		.idx        (st_idx),
		.fill_wdata (st_fill + 1'b1),
		.hid_wdata  (hid_q),
		.dl_wdata   (dl_q),
		.fill       (st_fill),
		.hid        (st_hid),
		.dl         (st_dl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						state_q <= (cmd.mode == MODE_TICK) ? S_TFILL : S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= q_over ? S_IRESP : S_FCHK;
					end
				end
				S_FCHK: begin
					state_q <= S_IRESP;
				end
				S_IRESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TFILL: begin
					if (st_fill == '0) begin
						cur_q   <= cur_nx;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_TOUT;
					end
				end
				S_TOUT: begin
					if (out_free && tout_last) begin
						cur_q   <= cur_nx;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			dl_q  <= cmd.deadline;
			hid_q <= cmd.handler_id;
		end
		if ((state_q == S_DIV) && div_done) begin
			slot_q   <= slot_nx;
			status_q <= q_over ? ST_SPAN : ST_OK;
		end
		if ((state_q == S_FCHK) && fill_full) begin
			status_q <= ST_FULL;
		end
		if (state_q == S_TFILL) begin
			n_q   <= st_fill;
			idx_q <= '0;
		end else if (rpt_load_exp) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Report register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (rpt_load_inst || rpt_load_exp) begin
			rpt_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_load_inst) begin
			rpt_kind_q   <= KIND_INSTALL;
			rpt_status_q <= status_q;
			rpt_hid_q    <= '0;
			rpt_dl_q     <= '0;
			rpt_last_q   <= 1'b1;
		end else if (rpt_load_exp) begin
			rpt_kind_q   <= KIND_EXPIRE;
			rpt_status_q <= ST_OK;
			rpt_hid_q    <= st_hid;
			rpt_dl_q     <= st_dl;
			rpt_last_q   <= tout_last;
		end
	end

	assign rpt.valid          = rpt_valid_q;
	assign rpt.kind           = rpt_kind_q;
	assign rpt.status         = rpt_status_q;
	assign rpt.fired_handler  = rpt_hid_q;
	assign rpt.fired_deadline = rpt_dl_q;
	assign rpt.last           = rpt_last_q;

`ifndef SYNTHESIS
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q < SLOT_W'(SLOTS))
		else $error("slot pointer out of range");

	a_drain_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOUT) |-> (idx_q < n_q))
		else $error("drain index passed the slot fill");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside an install");

	a_inst_rpt: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid_q && (rpt_kind_q == KIND_INSTALL)) |->
		(rpt_last_q && (rpt_hid_q == '0) && (rpt_dl_q == '0)))
		else $error("install report carries timer fields");

	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_TFILL) && (st_fill == '0)) |=> (cur_q == $past(cur_nx)))
		else $error("empty tick did not advance the slot pointer");
`endif

endmodule

`default_nettype wire

### dv/timing_wheel_checker.sv
// ----------------------------------------------------------------------------
// Timing wheel scheduler checker
// Watches the request channel, the report channel and register writes. It
// keeps its own copy of the wheel, works out the reports each accepted request
// should cause, and compares every accepted report field by field with the
// oldest one still outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module timing_wheel_checker import tws_pkg::*; #(
	parameter int SLOTS            = SLOTS_DEF,
	parameter int ENTRIES_PER_SLOT = ENTRIES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tws_cmd_if                     cmd,
	tws_rpt_if                     rpt,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output int                     outstanding,
	output int                     fail_count
);

	typedef struct packed {
		logic                kind;
		logic [STATUS_W-1:0] status;
		logic [HID_W-1:0]    handler;
		logic [DATA_W-1:0]   deadline;
		logic                last;
	} wheel_report_t;

	logic [DATA_W-1:0] granularity;
	int                wheel_pos;
	int                slot_fill [SLOTS];
	logic [HID_W-1:0]  slot_handler [SLOTS][ENTRIES_PER_SLOT];
	logic [DATA_W-1:0] slot_deadline [SLOTS][ENTRIES_PER_SLOT];
	wheel_report_t     expected_reports [$];

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("%0t: report mismatch on %s: got 0x%0h, expected 0x%0h",
			$time, what, got, want);
		fail_count++;
	endtask

	task automatic install_or_expire(input logic mode, input logic [DATA_W-1:0] deadline,
			input logic [HID_W-1:0] hid);
		wheel_report_t r;
		logic [DATA_W-1:0] quotient;
		int slot;
		int n;
		r = '0;
		if (mode == MODE_INSTALL) begin
			r.kind   = KIND_INSTALL;
			r.status = ST_OK;
			r.last   = 1'b1;
			if (granularity == '0) begin
				r.status = ST_SPAN;
			end else begin
				quotient = deadline / granularity;
				if (quotient >= SLOTS) begin
					r.status = ST_SPAN;
				end else begin
					slot = (wheel_pos + int'(quotient)) % SLOTS;
					if (slot_fill[slot] >= ENTRIES_PER_SLOT) begin
						r.status = ST_FULL;
					end else begin
						slot_handler[slot][slot_fill[slot]]  = hid;
						slot_deadline[slot][slot_fill[slot]] = deadline;
						slot_fill[slot]++;
					end
				end
			end
			expected_reports.push_back(r);
		end else begin
			n = slot_fill[wheel_pos];
			for (int i = 0; i < n; i++) begin
				r.kind     = KIND_EXPIRE;
				r.status   = ST_OK;
				r.handler  = slot_handler[wheel_pos][i];
				r.deadline = slot_deadline[wheel_pos][i];
				r.last     = (i == n - 1);
				expected_reports.push_back(r);
			end
			slot_fill[wheel_pos] = 0;
			wheel_pos = (wheel_pos + 1) % SLOTS;
		end
	endtask

	task automatic check_report();
		wheel_report_t want;
		if (expected_reports.size() == 0) begin
			report_mismatch("report with none outstanding", rpt.fired_deadline, '0);
			return;
		end
		want = expected_reports.pop_front();
		if (rpt.kind !== want.kind)
			report_mismatch("kind", rpt.kind, want.kind);
		if (rpt.status !== want.status)
			report_mismatch("status", rpt.status, want.status);
		if (rpt.fired_handler !== want.handler)
			report_mismatch("fired_handler", rpt.fired_handler, want.handler);
		if (rpt.fired_deadline !== want.deadline)
			report_mismatch("fired_deadline", rpt.fired_deadline, want.deadline);
		if (rpt.last !== want.last)
			report_mismatch("last", rpt.last, want.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			granularity = GRAN_RESET;
			wheel_pos   = 0;
			foreach (slot_fill[i])
				slot_fill[i] = 0;
			expected_reports.delete();
			outstanding <= 0;
		end else begin
			if (rpt.valid && rpt.ready)
				check_report();
			if (cmd.valid && cmd.ready)
				install_or_expire(cmd.mode, cmd.deadline, cmd.handler_id);
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00
					&& (paddr >> 2) == REG_GRAN)
				granularity = pwdata[DATA_W-1:0];
			outstanding <= expected_reports.size();
		end
	end

endmodule

`default_nettype wire

### dv/tb_timing_wheel_scheduler_top.sv
// ----------------------------------------------------------------------------
// Timing wheel scheduler testbench
// Drives install and tick requests and granularity writes into the wheel,
// first a directed set of corner cases, then three random phases with
// different idling on both channels and different granularities. A long
// stall of the report channel fills the block up once. The checker beside
// the block predicts and compares every report.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_timing_wheel_scheduler_top;
	import tws_pkg::*;

	localparam int HALF_PERIOD      = 10;
	localparam int RESET_CYCLES     = 3;
	localparam int SETTLE_CYCLES    = 40;
	localparam int HOLD_CYCLES      = 600;
	localparam int QUIET_LIMIT      = 5000;
	localparam int RANDOM_PER_PHASE = 115;

	localparam logic [APB_AW-1:0] GRAN_ADDR  = APB_AW'(4 * REG_GRAN);
	localparam logic [APB_AW-1:0] SPARE_ADDR = GRAN_ADDR + APB_AW'(4);

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int                tx_idle_pct  = 0;
	int                rx_idle_pct  = 0;
	int                hold_req     = 0;
	int                quiet_cycles = 0;
	int                outstanding;
	int                fail_count;
	logic [DATA_W-1:0] gran_now;

	tws_cmd_if cmd_ch ();
	tws_rpt_if rpt_ch ();

	timing_wheel_scheduler_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rpt     (rpt_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	timing_wheel_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.rpt         (rpt_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rpt_ch.valid && rpt_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// The report side stalls at random, and holds off for a long stretch
	// whenever the request side asks for it.
	initial begin : report_sink
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		rpt_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rpt_ch.ready <= 1'b0;
			end else begin
				rpt_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_request(input logic mode, input logic [DATA_W-1:0] deadline,
			input logic [HID_W-1:0] hid);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.mode       <= mode;
		cmd_ch.deadline   <= deadline;
		cmd_ch.handler_id <= hid;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	task automatic quiesce();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] value);
		quiesce();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == GRAN_ADDR)
			gran_now = value;
	endtask

	// Installs mostly land inside the wheel span, with the span edges and
	// arbitrary deadlines mixed in.
	task automatic send_random_request(input int tick_pct);
		logic [63:0] wide;
		if ($urandom_range(99) < tick_pct) begin
			send_request(MODE_TICK, $urandom, HID_W'($urandom));
			return;
		end
		case ($urandom_range(9))
			0: wide = $urandom;
			1: wide = 64'(gran_now) * SLOTS_DEF - 1;
			2: wide = 64'(gran_now) * SLOTS_DEF;
			3, 4, 5: wide = 64'(gran_now) * $urandom_range(1) + $urandom_range(gran_now - 1);
			default: wide = 64'(gran_now) * $urandom_range(SLOTS_DEF - 1)
				+ $urandom_range(gran_now - 1);
		endcase
		send_request(MODE_INSTALL, (wide > 64'hFFFF_FFFF) ? $urandom : wide[DATA_W-1:0],
			HID_W'($urandom));
	endtask

	// Bursts aimed at the current slot fill it and can overflow it.
	task automatic run_random_phase(input int n_items, input int tick_pct);
		int sent;
		int burst;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(19) == 0) begin
				burst = $urandom_range(ENTRIES_DEF + 2, ENTRIES_DEF);
				repeat (burst)
					send_request(MODE_INSTALL, $urandom_range(gran_now - 1), HID_W'($urandom));
				sent += burst;
			end else begin
				send_random_request(tick_pct);
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		cmd_ch.valid      <= 1'b0;
		cmd_ch.mode       <= MODE_INSTALL;
		cmd_ch.deadline   <= '0;
		cmd_ch.handler_id <= '0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		gran_now    = GRAN_RESET;
		tx_idle_pct = 25;
		rx_idle_pct = 82;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MODE_INSTALL, '0, '0);
		send_request(MODE_INSTALL, GRAN_RESET * SLOTS_DEF - 1, '1);
		send_request(MODE_INSTALL, GRAN_RESET * SLOTS_DEF, 8'h01);
		send_request(MODE_INSTALL, '1, 8'h5A);
		for (int i = 0; i < ENTRIES_DEF; i++)
			send_request(MODE_INSTALL, GRAN_RESET + i * 7, HID_W'(8'h10 + i));
		send_request(MODE_INSTALL, 2 * GRAN_RESET - 1, 8'hA5);
		send_request(MODE_TICK, '0, '0);
		send_request(MODE_TICK, '1, '1);
		send_request(MODE_TICK, '0, '0);

		write_register(GRAN_ADDR, '0);
		send_request(MODE_INSTALL, '0, 8'h33);
		write_register(SPARE_ADDR, 32'd5);
		send_request(MODE_INSTALL, 32'd3, 8'h44);
		write_register(GRAN_ADDR, 32'd1);
		send_request(MODE_INSTALL, SLOTS_DEF - 1, 8'h55);
		send_request(MODE_INSTALL, SLOTS_DEF, 8'h66);
		write_register(GRAN_ADDR, '1);
		send_request(MODE_INSTALL, '1, 8'h77);
		send_request(MODE_INSTALL, 32'hFFFF_FFFE, 8'h88);
		send_request(MODE_TICK, '0, '0);

		write_register(GRAN_ADDR, GRAN_RESET);
		hold_req <= hold_req + 1;
		run_random_phase(RANDOM_PER_PHASE, 12);

		write_register(GRAN_ADDR, $urandom_range(64, 1));
		tx_idle_pct = 82;
		rx_idle_pct = 25;
		run_random_phase(RANDOM_PER_PHASE, 15);

		write_register(GRAN_ADDR, $urandom_range(32'hFFFF_FFFF / SLOTS_DEF, 32'h0800_0000));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random_phase(RANDOM_PER_PHASE, 15);

		quiesce();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
